// ===== rtl/aesp_pkg.sv =====
// ----------------------------------------------------------------------------
// aesp_pkg
// shared types and constants of the terminal escape sequence parser
// ----------------------------------------------------------------------------
package aesp_pkg;

    // parser modes of the byte front end
    typedef enum logic [2:0] {
        M_GROUND,
        M_ESC,
        M_CSI,
        M_OSC,
        M_OSC_ESC,
        M_SKIP
    } t_mode;

    // commands handed from the front end to the back end
    typedef enum logic [3:0] {
        OP_CHAR,
        OP_LF,
        OP_CR,
        OP_BEL,
        OP_BS,
        OP_TAB,
        OP_SGR,
        OP_UP,
        OP_DOWN,
        OP_RIGHT,
        OP_LEFT,
        OP_POS,
        OP_COL,
        OP_ED,
        OP_EL
    } t_op;

    localparam int unsigned OP_BITS = 4;

    // back end states
    typedef enum logic [2:0] {
        B_RUN,
        B_WALK,
        B_EXT_SEL,
        B_EXT_PAL,
        B_EXT_R,
        B_EXT_G,
        B_EXT_B
    } t_bstate;

    // result kinds
    localparam logic [2:0] K_CHAR    = 3'd0;
    localparam logic [2:0] K_LF      = 3'd1;
    localparam logic [2:0] K_CR      = 3'd2;
    localparam logic [2:0] K_BEL     = 3'd3;
    localparam logic [2:0] K_MOVE    = 3'd4;
    localparam logic [2:0] K_POS     = 3'd5;
    localparam logic [2:0] K_ERASE_D = 3'd6;
    localparam logic [2:0] K_ERASE_L = 3'd7;

    // colour types
    localparam logic [2:0] C_DEFAULT = 3'd0;
    localparam logic [2:0] C_STD     = 3'd1;
    localparam logic [2:0] C_BRIGHT  = 3'd2;
    localparam logic [2:0] C_PALETTE = 3'd3;
    localparam logic [2:0] C_RGB     = 3'd4;

    // byte codes
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_UP     = 8'h41;
    localparam logic [7:0] CH_DOWN   = 8'h42;
    localparam logic [7:0] CH_RIGHT  = 8'h43;
    localparam logic [7:0] CH_LEFT   = 8'h44;
    localparam logic [7:0] CH_COL    = 8'h47;
    localparam logic [7:0] CH_POS    = 8'h48;
    localparam logic [7:0] CH_ED     = 8'h4A;
    localparam logic [7:0] CH_EL     = 8'h4B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_POS_F  = 8'h66;
    localparam logic [7:0] CH_SGR    = 8'h6D;

    // sgr codes
    localparam int unsigned SGR_RESET     = 0;
    localparam int unsigned SGR_BOLD      = 1;
    localparam int unsigned SGR_DIM       = 2;
    localparam int unsigned SGR_ITALIC    = 3;
    localparam int unsigned SGR_UNDER     = 4;
    localparam int unsigned SGR_INVERSE   = 7;
    localparam int unsigned SGR_HIDDEN    = 8;
    localparam int unsigned SGR_STRIKE    = 9;
    localparam int unsigned SGR_NO_BOLD   = 22;
    localparam int unsigned SGR_NO_ITAL   = 23;
    localparam int unsigned SGR_NO_UNDER  = 24;
    localparam int unsigned SGR_NO_INV    = 27;
    localparam int unsigned SGR_NO_HIDE   = 28;
    localparam int unsigned SGR_NO_STRIKE = 29;
    localparam int unsigned SGR_FG_BASE   = 30;
    localparam int unsigned SGR_FG_EXT    = 38;
    localparam int unsigned SGR_FG_DEF    = 39;
    localparam int unsigned SGR_BG_BASE   = 40;
    localparam int unsigned SGR_BG_EXT    = 48;
    localparam int unsigned SGR_BG_DEF    = 49;
    localparam int unsigned SGR_FG_BRIGHT = 90;
    localparam int unsigned SGR_BG_BRIGHT = 100;
    localparam int unsigned SGR_SEL_RGB   = 2;
    localparam int unsigned SGR_SEL_PAL   = 5;

    // current text attributes
    typedef struct packed {
        logic [6:0]  style;
        logic [2:0]  fg_type;
        logic [7:0]  fg_index;
        logic [23:0] fg_rgb;
        logic [2:0]  bg_type;
        logic [7:0]  bg_index;
        logic [23:0] bg_rgb;
    } t_attr;

endpackage

// ===== rtl/aesp_if.sv =====
// ----------------------------------------------------------------------------
// aesp_in_if / aesp_out_if
// valid/ready channels of the escape sequence parser
// ----------------------------------------------------------------------------
interface aesp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface aesp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [7:0]         character;
    logic signed [16:0] row_value;
    logic signed [16:0] col_value;
    logic [6:0]         style_flags;
    logic [2:0]         fg_type;
    logic [7:0]         fg_index;
    logic [23:0]        fg_rgb;
    logic [2:0]         bg_type;
    logic [7:0]         bg_index;
    logic [23:0]        bg_rgb;
    logic               last;

    modport source (output valid, output kind, output character, output row_value,
                    output col_value, output style_flags, output fg_type,
                    output fg_index, output fg_rgb, output bg_type, output bg_index,
                    output bg_rgb, output last, input ready);
    modport sink   (input valid, input kind, input character, input row_value,
                    input col_value, input style_flags, input fg_type,
                    input fg_index, input fg_rgb, input bg_type, input bg_index,
                    input bg_rgb, input last, output ready);
    modport monitor (input valid, input kind, input character, input row_value,
                     input col_value, input style_flags, input fg_type,
                     input fg_index, input fg_rgb, input bg_type, input bg_index,
                     input bg_rgb, input last, input ready);
endinterface

// ===== rtl/aesp_queue.sv =====
// ----------------------------------------------------------------------------
// aesp_queue
// two-entry command queue between front end and back end
// ----------------------------------------------------------------------------
module aesp_queue #(
    parameter int unsigned W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== rtl/aesp_front.sv =====
// ----------------------------------------------------------------------------
// aesp_front
// byte front end: parser modes, csi parameter collection, command issue
// ----------------------------------------------------------------------------
module aesp_front #(
    parameter int unsigned MAX_PARAMS = 16,
    parameter int unsigned PARAM_BITS = 16,
    parameter int unsigned AW = $clog2(MAX_PARAMS),
    parameter int unsigned CW = $clog2(MAX_PARAMS + 1),
    parameter int unsigned QW = 4 + 8 + CW + 2 * PARAM_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    aesp_in_if.sink               i_in,
    output logic                  o_push,
    output logic [QW-1:0]         o_cmd,
    input  logic                  i_q_full,
    input  logic                  i_sgr_done,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [PARAM_BITS-1:0] o_rd_data
);
    import aesp_pkg::*;

    localparam logic [PARAM_BITS-1:0] PMAX = {PARAM_BITS{1'b1}};
    localparam logic [CW-1:0]         CMAX = CW'(MAX_PARAMS);

    t_mode                 r_mode, n_mode;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [PARAM_BITS-1:0] r_acc, n_acc, r_p0, n_p0, r_p1, n_p1;
    logic                  r_done, n_done, r_has, n_has, r_sgr_pend, n_sgr_pend;
    logic [PARAM_BITS-1:0] r_store [MAX_PARAMS];

    logic                  take, is_digit, we;
    logic [7:0]            b;
    logic [PARAM_BITS+3:0] acc_x10;
    logic [CW-1:0]         cnt_fin;
    logic [PARAM_BITS-1:0] p0_fin, p1_fin;
    t_op                   op;

    assign b        = i_in.in_byte;
    assign i_in.ready = !i_q_full && !r_sgr_pend;
    assign take     = i_in.valid && i_in.ready;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign acc_x10  = ({4'd0, r_acc} * (PARAM_BITS+4)'(10)) + (PARAM_BITS+4)'(b[3:0]);
    assign o_rd_data = r_store[i_rd_addr];

    // parameter count and leading parameters as the final byte sees them
    always_comb begin
        cnt_fin = r_cnt + CW'(r_has && (r_cnt < CMAX));
        if (cnt_fin == '0) cnt_fin = CW'(1);
        p0_fin = (r_cnt == '0) ? r_acc : r_p0;
        p1_fin = (r_cnt == '0) ? '0 : ((r_cnt == CW'(1)) ? r_acc : r_p1);
    end

    // next mode
    always_comb begin
        n_mode = r_mode;
        if (take) begin
            unique case (r_mode)
                M_GROUND:  n_mode = (b == CH_ESC) ? M_ESC : M_GROUND;
                M_ESC: begin
                    if (b == CH_LBRACK)                         n_mode = M_CSI;
                    else if (b == CH_RBRACK)                    n_mode = M_OSC;
                    else if (b == CH_LPAREN || b == CH_RPAREN)  n_mode = M_SKIP;
                    else                                        n_mode = M_GROUND;
                end
                M_SKIP:    n_mode = M_GROUND;
                M_CSI: begin
                    if (!(is_digit || b == CH_QUEST || b == CH_GT || b == CH_SEMI))
                        n_mode = M_GROUND;
                end
                M_OSC: begin
                    if (b == CH_BEL)      n_mode = M_GROUND;
                    else if (b == CH_ESC) n_mode = M_OSC_ESC;
                end
                M_OSC_ESC: n_mode = (b == CH_BSLASH) ? M_GROUND : M_OSC;
                default:   n_mode = M_GROUND;
            endcase
        end
    end

    // command issue and parameter datapath
    always_comb begin
        o_push     = 1'b0;
        op         = OP_CHAR;
        we         = 1'b0;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_p0       = r_p0;
        n_p1       = r_p1;
        n_done     = r_done;
        n_has      = r_has;
        n_sgr_pend = r_sgr_pend && !i_sgr_done;
        if (take) begin
            unique case (r_mode)
                M_GROUND: begin
                    o_push = 1'b1;
                    if (b == CH_LF)          op = OP_LF;
                    else if (b == CH_CR)     op = OP_CR;
                    else if (b == CH_BEL)    op = OP_BEL;
                    else if (b == CH_BS)     op = OP_BS;
                    else if (b == CH_TAB)    op = OP_TAB;
                    else if (b >= CH_SPACE)  op = OP_CHAR;
                    else                     o_push = 1'b0;
                end
                M_ESC: begin
                    if (b == CH_LBRACK) begin
                        n_cnt  = '0;
                        n_acc  = '0;
                        n_done = 1'b0;
                        n_has  = 1'b0;
                    end
                end
                M_CSI: begin
                    if (is_digit) begin
                        n_has = 1'b1;
                        if (!r_done && r_cnt < CMAX)
                            n_acc = (acc_x10 > {4'd0, PMAX}) ? PMAX
                                                             : acc_x10[PARAM_BITS-1:0];
                    end else if (b == CH_QUEST || b == CH_GT) begin
                        n_has  = 1'b1;
                        n_done = 1'b1;
                    end else if (b == CH_SEMI) begin
                        if (r_cnt < CMAX) begin
                            we    = 1'b1;
                            n_cnt = r_cnt + CW'(1);
                            if (r_cnt == '0)     n_p0 = r_acc;
                            if (r_cnt == CW'(1)) n_p1 = r_acc;
                        end
                        n_acc  = '0;
                        n_done = 1'b0;
                        n_has  = 1'b0;
                    end else begin
                        we     = (r_cnt < CMAX);
                        o_push = 1'b1;
                        unique case (b)
                            CH_SGR:           op = OP_SGR;
                            CH_UP:            op = OP_UP;
                            CH_DOWN:          op = OP_DOWN;
                            CH_RIGHT:         op = OP_RIGHT;
                            CH_LEFT:          op = OP_LEFT;
                            CH_POS, CH_POS_F: op = OP_POS;
                            CH_COL:           op = OP_COL;
                            CH_ED:            op = OP_ED;
                            CH_EL:            op = OP_EL;
                            default:          o_push = 1'b0;
                        endcase
                        if (b == CH_SGR) n_sgr_pend = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        o_cmd = {op, b, cnt_fin, p0_fin, p1_fin};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_GROUND;
            r_cnt      <= '0;
            r_done     <= 1'b0;
            r_has      <= 1'b0;
            r_sgr_pend <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_cnt      <= n_cnt;
            r_done     <= n_done;
            r_has      <= n_has;
            r_sgr_pend <= n_sgr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_p0  <= n_p0;
        r_p1  <= n_p1;
        if (we) r_store[r_cnt[AW-1:0]] <= r_acc;
    end
endmodule

// ===== rtl/aesp_back.sv =====
// ----------------------------------------------------------------------------
// aesp_back
// back end: result generation, tab expansion and sgr parameter walk
// ----------------------------------------------------------------------------
module aesp_back #(
    parameter int unsigned MAX_PARAMS = 16,
    parameter int unsigned PARAM_BITS = 16,
    parameter int unsigned AW = $clog2(MAX_PARAMS),
    parameter int unsigned CW = $clog2(MAX_PARAMS + 1),
    parameter int unsigned QW = 4 + 8 + CW + 2 * PARAM_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  logic [QW-1:0]         i_cmd,
    output logic                  o_pop,
    output logic                  o_sgr_done,
    output logic [AW-1:0]         o_rd_addr,
    input  logic [PARAM_BITS-1:0] i_rd_data,
    aesp_out_if.source            o_out
);
    import aesp_pkg::*;

    localparam int unsigned PB = PARAM_BITS;

    t_bstate       r_state, n_state;
    t_attr         r_attr, n_attr, r_oattr;
    logic [CW-1:0] r_i, n_i, r_n, n_n;
    logic [2:0]    r_tab, n_tab;
    logic          r_fg, n_fg;
    logic [15:0]   r_rg, n_rg;
    logic          r_ov, n_ov, load;
    logic [2:0]    r_kind, n_kind;
    logic [7:0]    r_ch, n_ch;
    logic [16:0]   r_row, n_row, r_col, n_col;
    logic          r_last, n_last;

    t_op           op;
    logic [7:0]    ch;
    logic [CW-1:0] cnt;
    logic [PB-1:0] p0, p1, v;
    logic [31:0]   amt, pm0, pm1;
    logic          can_emit;

    assign op  = t_op'(i_cmd[QW-1 -: OP_BITS]);
    assign ch  = i_cmd[QW-OP_BITS-1 -: 8];
    assign cnt = i_cmd[2*PB +: CW];
    assign p0  = i_cmd[PB +: PB];
    assign p1  = i_cmd[0 +: PB];
    assign v   = i_rd_data;
    assign o_rd_addr = r_i[AW-1:0];
    assign can_emit  = !r_ov || o_out.ready;
    assign amt = (p0 == '0) ? 32'd1 : 32'(p0);
    assign pm0 = (p0 == '0) ? 32'd0 : 32'(p0) - 32'd1;
    assign pm1 = (p1 == '0) ? 32'd0 : 32'(p1) - 32'd1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_RUN:     if (!i_q_empty && op == OP_SGR) n_state = B_WALK;
            B_WALK: begin
                if (r_i >= r_n)                                    n_state = B_RUN;
                else if (v == PB'(SGR_FG_EXT) || v == PB'(SGR_BG_EXT)) n_state = B_EXT_SEL;
            end
            B_EXT_SEL: begin
                if ((CW+2)'(r_i) + (CW+2)'(1) < (CW+2)'(r_n) && v == PB'(SGR_SEL_PAL))
                    n_state = B_EXT_PAL;
                else if ((CW+2)'(r_i) + (CW+2)'(3) < (CW+2)'(r_n) && v == PB'(SGR_SEL_RGB))
                    n_state = B_EXT_R;
                else
                    n_state = B_WALK;
            end
            B_EXT_PAL: n_state = B_WALK;
            B_EXT_R:   n_state = B_EXT_G;
            B_EXT_G:   n_state = B_EXT_B;
            B_EXT_B:   n_state = B_WALK;
            default:   n_state = B_RUN;
        endcase
    end

    // datapath and handshakes
    always_comb begin
        n_attr     = r_attr;
        n_i        = r_i;
        n_n        = r_n;
        n_tab      = r_tab;
        n_fg       = r_fg;
        n_rg       = r_rg;
        o_pop      = 1'b0;
        o_sgr_done = 1'b0;
        load       = 1'b0;
        n_kind     = K_CHAR;
        n_ch       = '0;
        n_row      = '0;
        n_col      = '0;
        n_last     = 1'b1;
        unique case (r_state)
            B_RUN: begin
                if (!i_q_empty) begin
                    if (op == OP_SGR) begin
                        n_i = '0;
                        n_n = cnt;
                    end else if (can_emit) begin
                        load  = 1'b1;
                        o_pop = 1'b1;
                        case (op)
                            OP_CHAR:  n_ch = ch;
                            OP_LF:    n_kind = K_LF;
                            OP_CR:    n_kind = K_CR;
                            OP_BEL:   n_kind = K_BEL;
                            OP_BS: begin
                                n_kind = K_MOVE;
                                n_col  = '1;
                            end
                            OP_TAB: begin
                                // eight spaces, the queue entry stays until the last
                                n_ch   = CH_SPACE;
                                n_last = (r_tab == 3'd7);
                                o_pop  = (r_tab == 3'd7);
                                n_tab  = r_tab + 3'd1;
                            end
                            OP_UP: begin
                                n_kind = K_MOVE;
                                n_row  = 17'(32'd0 - amt);
                            end
                            OP_DOWN: begin
                                n_kind = K_MOVE;
                                n_row  = amt[16:0];
                            end
                            OP_RIGHT: begin
                                n_kind = K_MOVE;
                                n_col  = amt[16:0];
                            end
                            OP_LEFT: begin
                                n_kind = K_MOVE;
                                n_col  = 17'(32'd0 - amt);
                            end
                            OP_POS: begin
                                n_kind = K_POS;
                                n_row  = pm0[16:0];
                                n_col  = pm1[16:0];
                            end
                            OP_COL: begin
                                n_kind = K_POS;
                                n_row  = '1;
                                n_col  = pm0[16:0];
                            end
                            OP_ED: begin
                                n_kind = K_ERASE_D;
                                n_col  = 17'(p0);
                            end
                            OP_EL: begin
                                n_kind = K_ERASE_L;
                                n_col  = 17'(p0);
                            end
                            default: load = 1'b0;
                        endcase
                    end
                end
            end
            B_WALK: begin
                if (r_i >= r_n) begin
                    o_pop      = 1'b1;
                    o_sgr_done = 1'b1;
                end else begin
                    n_i = r_i + CW'(1);
                    if (v == PB'(SGR_RESET))          n_attr = '0;
                    else if (v == PB'(SGR_BOLD))      n_attr.style[0] = 1'b1;
                    else if (v == PB'(SGR_DIM))       n_attr.style[1] = 1'b1;
                    else if (v == PB'(SGR_ITALIC))    n_attr.style[2] = 1'b1;
                    else if (v == PB'(SGR_UNDER))     n_attr.style[3] = 1'b1;
                    else if (v == PB'(SGR_INVERSE))   n_attr.style[4] = 1'b1;
                    else if (v == PB'(SGR_HIDDEN))    n_attr.style[5] = 1'b1;
                    else if (v == PB'(SGR_STRIKE))    n_attr.style[6] = 1'b1;
                    else if (v == PB'(SGR_NO_BOLD))   n_attr.style[1:0] = 2'b00;
                    else if (v == PB'(SGR_NO_ITAL))   n_attr.style[2] = 1'b0;
                    else if (v == PB'(SGR_NO_UNDER))  n_attr.style[3] = 1'b0;
                    else if (v == PB'(SGR_NO_INV))    n_attr.style[4] = 1'b0;
                    else if (v == PB'(SGR_NO_HIDE))   n_attr.style[5] = 1'b0;
                    else if (v == PB'(SGR_NO_STRIKE)) n_attr.style[6] = 1'b0;
                    else if (v >= PB'(SGR_FG_BASE) && v <= PB'(SGR_FG_BASE + 7)) begin
                        n_attr.fg_type  = C_STD;
                        n_attr.fg_index = {5'd0, v[2:0] - 3'(SGR_FG_BASE)};
                    end else if (v >= PB'(SGR_BG_BASE) && v <= PB'(SGR_BG_BASE + 7)) begin
                        n_attr.bg_type  = C_STD;
                        n_attr.bg_index = {5'd0, v[2:0] - 3'(SGR_BG_BASE)};
                    end else if (v >= PB'(SGR_FG_BRIGHT) && v <= PB'(SGR_FG_BRIGHT + 7)) begin
                        n_attr.fg_type  = C_BRIGHT;
                        n_attr.fg_index = {5'd0, v[2:0] - 3'(SGR_FG_BRIGHT)};
                    end else if (v >= PB'(SGR_BG_BRIGHT) && v <= PB'(SGR_BG_BRIGHT + 7)) begin
                        n_attr.bg_type  = C_BRIGHT;
                        n_attr.bg_index = {5'd0, v[2:0] - 3'(SGR_BG_BRIGHT)};
                    end else if (v == PB'(SGR_FG_DEF)) begin
                        n_attr.fg_type  = C_DEFAULT;
                        n_attr.fg_index = '0;
                        n_attr.fg_rgb   = '0;
                    end else if (v == PB'(SGR_BG_DEF)) begin
                        n_attr.bg_type  = C_DEFAULT;
                        n_attr.bg_index = '0;
                        n_attr.bg_rgb   = '0;
                    end else if (v == PB'(SGR_FG_EXT) || v == PB'(SGR_BG_EXT)) begin
                        n_fg = (v == PB'(SGR_FG_EXT));
                    end
                end
            end
            B_EXT_SEL: begin
                // a short operand list or an unknown selector leaves the index on the selector
                if (n_state != B_WALK) n_i = r_i + CW'(1);
            end
            B_EXT_PAL: begin
                n_i = r_i + CW'(1);
                if (r_fg) begin
                    n_attr.fg_type  = C_PALETTE;
                    n_attr.fg_index = v[7:0];
                end else begin
                    n_attr.bg_type  = C_PALETTE;
                    n_attr.bg_index = v[7:0];
                end
            end
            B_EXT_R: begin
                n_i        = r_i + CW'(1);
                n_rg[15:8] = v[7:0];
            end
            B_EXT_G: begin
                n_i       = r_i + CW'(1);
                n_rg[7:0] = v[7:0];
            end
            B_EXT_B: begin
                n_i = r_i + CW'(1);
                if (r_fg) begin
                    n_attr.fg_type = C_RGB;
                    n_attr.fg_rgb  = {r_rg, v[7:0]};
                end else begin
                    n_attr.bg_type = C_RGB;
                    n_attr.bg_rgb  = {r_rg, v[7:0]};
                end
            end
            default: ;
        endcase
        n_ov = load || (r_ov && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_RUN;
            r_attr  <= '0;
            r_tab   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_attr  <= n_attr;
            r_tab   <= n_tab;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i  <= n_i;
        r_n  <= n_n;
        r_fg <= n_fg;
        r_rg <= n_rg;
        if (load) begin
            r_kind  <= n_kind;
            r_ch    <= n_ch;
            r_row   <= n_row;
            r_col   <= n_col;
            r_last  <= n_last;
            r_oattr <= r_attr;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.kind        = r_kind;
    assign o_out.character   = r_ch;
    assign o_out.row_value   = r_row;
    assign o_out.col_value   = r_col;
    assign o_out.style_flags = r_oattr.style;
    assign o_out.fg_type     = r_oattr.fg_type;
    assign o_out.fg_index    = r_oattr.fg_index;
    assign o_out.fg_rgb      = r_oattr.fg_rgb;
    assign o_out.bg_type     = r_oattr.bg_type;
    assign o_out.bg_index    = r_oattr.bg_index;
    assign o_out.bg_rgb      = r_oattr.bg_rgb;
    assign o_out.last        = r_last;
endmodule

// ===== rtl/ansi_escape_sequence_parser.sv =====
// ----------------------------------------------------------------------------
// ansi_escape_sequence_parser
// terminal byte stream parser with csi decode and sgr attribute tracking
// ----------------------------------------------------------------------------
//  channel   dir  payload                                     handshake
//  i_in      in   in_byte                                     valid/ready
//  o_out     out  kind, character, row/col value, attributes  valid/ready
//
//  one byte per cycle in the front end while the queue has room and no sgr
//  walk is pending; results leave one per cycle while o_out is ready and no
//  sgr walk runs; a tab holds its queue entry until all eight spaces are out
//  an sgr final byte holds the input until the single-port parameter walk ends
//  a two-entry command queue sits between byte parsing and result generation
//  synchronous active-low reset clears parser mode, attributes and queue
// ----------------------------------------------------------------------------
module ansi_escape_sequence_parser #(
    parameter int unsigned MAX_PARAMS = 16,
    parameter int unsigned PARAM_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aesp_in_if.sink    i_in,
    aesp_out_if.source o_out
);
    import aesp_pkg::*;

    localparam int unsigned AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int unsigned CW = $clog2(MAX_PARAMS + 1);
    localparam int unsigned QW = OP_BITS + 8 + CW + 2 * PARAM_BITS;

    logic                  push, pop, q_full, q_empty, sgr_done;
    logic [QW-1:0]         cmd_in, cmd_out;
    logic [AW-1:0]         rd_addr;
    logic [PARAM_BITS-1:0] rd_data;

    aesp_front #(
        .MAX_PARAMS(MAX_PARAMS), .PARAM_BITS(PARAM_BITS), .AW(AW), .CW(CW), .QW(QW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_push     (push),
        .o_cmd      (cmd_in),
        .i_q_full   (q_full),
        .i_sgr_done (sgr_done),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data)
    );

    aesp_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (cmd_out)
    );

    aesp_back #(
        .MAX_PARAMS(MAX_PARAMS), .PARAM_BITS(PARAM_BITS), .AW(AW), .CW(CW), .QW(QW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_cmd      (cmd_out),
        .o_pop      (pop),
        .o_sgr_done (sgr_done),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_out      (o_out)
    );
endmodule

// ===== rtl/aesp_checker.sv =====
// ----------------------------------------------------------------------------
// aesp_checker
// port-level checks of the escape sequence parser
// ----------------------------------------------------------------------------
module aesp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [2:0]  i_kind,
    input logic [7:0]  i_character,
    input logic [16:0] i_row,
    input logic [16:0] i_col,
    input logic        i_last
);
    import aesp_pkg::*;

    // a waiting result is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result withdrawn while stalled");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // only character items carry a byte, and only character items (the spaces of a tab) may be open
    a_char_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != K_CHAR |-> i_character == 8'd0 && i_last)
        else $error("non-character result carries a byte or is not last");

    // control kinds and characters carry no coordinates
    a_ctrl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == K_LF || i_kind == K_CR || i_kind == K_BEL
                    || i_kind == K_CHAR)
        |-> i_row == 17'd0 && i_col == 17'd0)
        else $error("control result carries coordinates");
endmodule

bind ansi_escape_sequence_parser aesp_checker u_aesp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_kind      (o_out.kind),
    .i_character (o_out.character),
    .i_row       (o_out.row_value),
    .i_col       (o_out.col_value),
    .i_last      (o_out.last)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives terminal byte streams into the escape sequence parser and checks
// every result against a local model of parser state and text attributes
// ----------------------------------------------------------------------------
module testbench;
    import aesp_pkg::*;

    localparam int unsigned NPAR = 16;
    localparam int unsigned PBITS = 16;
    localparam int unsigned PSAT = (1 << PBITS) - 1;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         character;
        logic signed [16:0] row_value;
        logic signed [16:0] col_value;
        t_attr              attr;
        logic               last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    aesp_in_if  byte_ch ();
    aesp_out_if res_ch ();

    ansi_escape_sequence_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch.sink),
        .o_out   (res_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // model state
    t_mode       mdl_mode;
    logic [15:0] mdl_par [NPAR];
    int unsigned mdl_cnt;
    logic        mdl_done;
    logic        mdl_content;
    t_attr       mdl_attr;

    t_result     expected_q [$];
    int          errors;
    int          bytes_sent;
    int          results_seen;
    int          send_idle_pct;
    int          recv_stall_pct;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("error: result %0d %s got %0h want %0h", results_seen, what, got, want);
    endtask

    function automatic void push_result(input logic [2:0] k, input logic [7:0] c,
                                        input int r, input int col);
        t_result e;
        e.kind = k;
        e.character = c;
        e.row_value = r[16:0];
        e.col_value = col[16:0];
        e.attr = mdl_attr;
        e.last = 1'b0;
        expected_q = {expected_q, e};
    endfunction

    function automatic void clear_fg();
        mdl_attr.fg_type = C_DEFAULT;
        mdl_attr.fg_index = '0;
        mdl_attr.fg_rgb = '0;
    endfunction

    function automatic void clear_bg();
        mdl_attr.bg_type = C_DEFAULT;
        mdl_attr.bg_index = '0;
        mdl_attr.bg_rgb = '0;
    endfunction

    function automatic void apply_sgr(input int unsigned n);
        int unsigned i;
        int unsigned v;
        logic [23:0] rgb;
        i = 0;
        while (i < n) begin
            v = mdl_par[i];
            if (v == SGR_RESET) begin
                mdl_attr = '0;
            end else if (v == SGR_BOLD) mdl_attr.style[0] = 1'b1;
            else if (v == SGR_DIM) mdl_attr.style[1] = 1'b1;
            else if (v == SGR_ITALIC) mdl_attr.style[2] = 1'b1;
            else if (v == SGR_UNDER) mdl_attr.style[3] = 1'b1;
            else if (v == SGR_INVERSE) mdl_attr.style[4] = 1'b1;
            else if (v == SGR_HIDDEN) mdl_attr.style[5] = 1'b1;
            else if (v == SGR_STRIKE) mdl_attr.style[6] = 1'b1;
            else if (v == SGR_NO_BOLD) mdl_attr.style[1:0] = 2'b00;
            else if (v == SGR_NO_ITAL) mdl_attr.style[2] = 1'b0;
            else if (v == SGR_NO_UNDER) mdl_attr.style[3] = 1'b0;
            else if (v == SGR_NO_INV) mdl_attr.style[4] = 1'b0;
            else if (v == SGR_NO_HIDE) mdl_attr.style[5] = 1'b0;
            else if (v == SGR_NO_STRIKE) mdl_attr.style[6] = 1'b0;
            else if (v >= SGR_FG_BASE && v <= SGR_FG_BASE + 7) begin
                mdl_attr.fg_type = C_STD;
                mdl_attr.fg_index = 8'(v - SGR_FG_BASE);
            end else if (v >= SGR_BG_BASE && v <= SGR_BG_BASE + 7) begin
                mdl_attr.bg_type = C_STD;
                mdl_attr.bg_index = 8'(v - SGR_BG_BASE);
            end else if (v >= SGR_FG_BRIGHT && v <= SGR_FG_BRIGHT + 7) begin
                mdl_attr.fg_type = C_BRIGHT;
                mdl_attr.fg_index = 8'(v - SGR_FG_BRIGHT);
            end else if (v >= SGR_BG_BRIGHT && v <= SGR_BG_BRIGHT + 7) begin
                mdl_attr.bg_type = C_BRIGHT;
                mdl_attr.bg_index = 8'(v - SGR_BG_BRIGHT);
            end else if (v == SGR_FG_DEF) clear_fg();
            else if (v == SGR_BG_DEF) clear_bg();
            else if (v == SGR_FG_EXT || v == SGR_BG_EXT) begin
                if (i + 2 < n && mdl_par[i + 1] == SGR_SEL_PAL) begin
                    if (v == SGR_FG_EXT) begin
                        mdl_attr.fg_type = C_PALETTE;
                        mdl_attr.fg_index = mdl_par[i + 2][7:0];
                    end else begin
                        mdl_attr.bg_type = C_PALETTE;
                        mdl_attr.bg_index = mdl_par[i + 2][7:0];
                    end
                    i += 2;
                end else if (i + 4 < n && mdl_par[i + 1] == SGR_SEL_RGB) begin
                    rgb = {mdl_par[i + 2][7:0], mdl_par[i + 3][7:0], mdl_par[i + 4][7:0]};
                    if (v == SGR_FG_EXT) begin
                        mdl_attr.fg_type = C_RGB;
                        mdl_attr.fg_rgb = rgb;
                    end else begin
                        mdl_attr.bg_type = C_RGB;
                        mdl_attr.bg_rgb = rgb;
                    end
                    i += 4;
                end
            end
            i++;
        end
    endfunction

    function automatic void finish_seq(input logic [7:0] fin);
        int unsigned cnt;
        int p0;
        int p1;
        int amt;
        cnt = mdl_cnt;
        if (mdl_content && cnt < NPAR) cnt++;
        if (cnt == 0) begin
            mdl_par[0] = '0;
            cnt = 1;
        end
        p0 = mdl_par[0];
        p1 = (cnt >= 2) ? int'(mdl_par[1]) : 0;
        amt = (p0 == 0) ? 1 : p0;
        case (fin)
            CH_SGR:   apply_sgr(cnt);
            CH_UP:    push_result(K_MOVE, 8'h00, -amt, 0);
            CH_DOWN:  push_result(K_MOVE, 8'h00, amt, 0);
            CH_RIGHT: push_result(K_MOVE, 8'h00, 0, amt);
            CH_LEFT:  push_result(K_MOVE, 8'h00, 0, -amt);
            CH_POS, CH_POS_F:
                push_result(K_POS, 8'h00, (p0 > 0) ? p0 - 1 : 0, (p1 > 0) ? p1 - 1 : 0);
            CH_COL:   push_result(K_POS, 8'h00, -1, (p0 > 0) ? p0 - 1 : 0);
            CH_ED:    push_result(K_ERASE_D, 8'h00, 0, p0);
            CH_EL:    push_result(K_ERASE_L, 8'h00, 0, p0);
            default: ;
        endcase
    endfunction

    // advances the model by one byte and queues what it produces
    function automatic void predict_byte(input logic [7:0] b);
        int base;
        int unsigned v;
        base = expected_q.size();
        case (mdl_mode)
            M_ESC: begin
                if (b == CH_LBRACK) begin
                    mdl_mode = M_CSI;
                    mdl_cnt = 0;
                    mdl_par[0] = '0;
                    mdl_done = 1'b0;
                    mdl_content = 1'b0;
                end else if (b == CH_RBRACK) mdl_mode = M_OSC;
                else if (b == CH_LPAREN || b == CH_RPAREN) mdl_mode = M_SKIP;
                else mdl_mode = M_GROUND;
            end
            M_SKIP: mdl_mode = M_GROUND;
            M_CSI: begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    mdl_content = 1'b1;
                    if (!mdl_done && mdl_cnt < NPAR) begin
                        v = mdl_par[mdl_cnt] * 10 + (b - CH_ZERO);
                        if (v > PSAT) v = PSAT;
                        mdl_par[mdl_cnt] = v[15:0];
                    end
                end else if (b == CH_QUEST || b == CH_GT) begin
                    mdl_content = 1'b1;
                    mdl_done = 1'b1;
                end else if (b == CH_SEMI) begin
                    if (mdl_cnt < NPAR) begin
                        mdl_cnt++;
                        if (mdl_cnt < NPAR) mdl_par[mdl_cnt] = '0;
                    end
                    mdl_done = 1'b0;
                    mdl_content = 1'b0;
                end else begin
                    finish_seq(b);
                    mdl_mode = M_GROUND;
                end
            end
            M_OSC: begin
                if (b == CH_BEL) mdl_mode = M_GROUND;
                else if (b == CH_ESC) mdl_mode = M_OSC_ESC;
            end
            M_OSC_ESC: mdl_mode = (b == CH_BSLASH) ? M_GROUND : M_OSC;
            default: begin
                mdl_mode = M_GROUND;
                if (b == CH_ESC) mdl_mode = M_ESC;
                else if (b == CH_LF) push_result(K_LF, 8'h00, 0, 0);
                else if (b == CH_CR) push_result(K_CR, 8'h00, 0, 0);
                else if (b == CH_BEL) push_result(K_BEL, 8'h00, 0, 0);
                else if (b == CH_BS) push_result(K_MOVE, 8'h00, 0, -1);
                else if (b == CH_TAB) begin
                    for (int k = 0; k < 8; k++) push_result(K_CHAR, CH_SPACE, 0, 0);
                end else if (b >= CH_SPACE) push_result(K_CHAR, b, 0, 0);
            end
        endcase
        if (expected_q.size() > base) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    // valid stays high from one item to the next unless the sender idles
    task automatic send_byte(input logic [7:0] b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.in_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_num(input int unsigned v);
        send_str($sformatf("%0d", v));
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        byte_ch.valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected", res_ch.kind, 0);
                end else begin
                    e = expected_q.pop_front();
                    if (res_ch.kind !== e.kind) report_mismatch("kind", res_ch.kind, e.kind);
                    if (res_ch.character !== e.character)
                        report_mismatch("character", res_ch.character, e.character);
                    if (res_ch.row_value !== e.row_value)
                        report_mismatch("row_value", res_ch.row_value, e.row_value);
                    if (res_ch.col_value !== e.col_value)
                        report_mismatch("col_value", res_ch.col_value, e.col_value);
                    if (res_ch.style_flags !== e.attr.style)
                        report_mismatch("style_flags", res_ch.style_flags, e.attr.style);
                    if (res_ch.fg_type !== e.attr.fg_type)
                        report_mismatch("fg_type", res_ch.fg_type, e.attr.fg_type);
                    if (res_ch.fg_index !== e.attr.fg_index)
                        report_mismatch("fg_index", res_ch.fg_index, e.attr.fg_index);
                    if (res_ch.fg_rgb !== e.attr.fg_rgb)
                        report_mismatch("fg_rgb", res_ch.fg_rgb, e.attr.fg_rgb);
                    if (res_ch.bg_type !== e.attr.bg_type)
                        report_mismatch("bg_type", res_ch.bg_type, e.attr.bg_type);
                    if (res_ch.bg_index !== e.attr.bg_index)
                        report_mismatch("bg_index", res_ch.bg_index, e.attr.bg_index);
                    if (res_ch.bg_rgb !== e.attr.bg_rgb)
                        report_mismatch("bg_rgb", res_ch.bg_rgb, e.attr.bg_rgb);
                    if (res_ch.last !== e.last) report_mismatch("last", res_ch.last, e.last);
                end
                results_seen++;
            end
        end
        res_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    task automatic test_controls();
        send_str("A~");
        send_byte(8'h20);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(CH_TAB);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_BEL);
        send_byte(CH_BS);
        send_byte(8'h00);
        send_byte(8'h1F);
    endtask

    task automatic test_csi_commands();
        send_byte(CH_ESC); send_str("[3A");
        send_byte(CH_ESC); send_str("[B");
        send_byte(CH_ESC); send_str("[0C");
        send_byte(CH_ESC); send_str("[99999D");
        send_byte(CH_ESC); send_str("[5;7H");
        send_byte(CH_ESC); send_str("[;f");
        send_byte(CH_ESC); send_str("[12G");
        send_byte(CH_ESC); send_str("[2J");
        send_byte(CH_ESC); send_str("[1K");
        send_byte(CH_ESC); send_str("[?25h");
        send_byte(CH_ESC); send_str("[>4;x1;");
        send_byte(CH_ESC); send_str("[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;18H");
    endtask

    task automatic test_sgr();
        send_byte(CH_ESC); send_str("[1;2;3;4;7;8;9mx");
        send_byte(CH_ESC); send_str("[22;23;24;27;28;29;31;47mx");
        send_byte(CH_ESC); send_str("[97;107mx");
        send_byte(CH_ESC); send_str("[38;5;300;48;2;255;0;128mx");
        send_byte(CH_ESC); send_str("[38;2;1;2;48;5mx");
        send_byte(CH_ESC); send_str("[39;49;mx");
        send_byte(CH_ESC); send_str("[1mx");
        send_byte(CH_ESC); send_str("[mx");
    endtask

    task automatic test_escapes();
        send_byte(CH_ESC); send_str("(Bq");
        send_byte(CH_ESC); send_str(")0q");
        send_byte(CH_ESC); send_str("Zq");
        send_byte(CH_ESC); send_str("]0;title"); send_byte(CH_BEL); send_str("q");
        send_byte(CH_ESC); send_str("]x"); send_byte(CH_ESC); send_str("a");
        send_byte(CH_ESC); send_byte(CH_BSLASH); send_str("q");
    endtask

    task automatic send_random_sequence();
        int unsigned n;
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 3) begin
            send_byte(8'($urandom_range(255)));
        end else if (sel < 8) begin
            send_byte(CH_ESC);
            send_byte(CH_LBRACK);
            n = $urandom_range(5);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(9))
                    0: send_num($urandom_range(65535) * 3);
                    1: send_byte(CH_QUEST);
                    2: ;
                    3: send_num($urandom_range(5) == 0 ? SGR_FG_EXT : SGR_BG_EXT);
                    4: send_num($urandom_range(1) ? SGR_SEL_PAL : SGR_SEL_RGB);
                    default: send_num($urandom_range(110));
                endcase
                if (i + 1 < n || $urandom_range(3) == 0) send_byte(CH_SEMI);
            end
            case ($urandom_range(11))
                0: send_byte(CH_UP);
                1: send_byte(CH_DOWN);
                2: send_byte(CH_RIGHT);
                3: send_byte(CH_LEFT);
                4: send_byte(CH_POS);
                5: send_byte(CH_POS_F);
                6: send_byte(CH_COL);
                7: send_byte(CH_ED);
                8: send_byte(CH_EL);
                9: send_byte(8'($urandom_range(8'h40, 8'h7E)));
                default: send_byte(CH_SGR);
            endcase
            send_byte(8'($urandom_range(8'h21, 8'hFF)));
        end else begin
            send_byte(CH_ESC);
            send_byte($urandom_range(1) ? CH_RBRACK : 8'($urandom_range(255)));
            send_byte(8'($urandom_range(255)));
            send_byte($urandom_range(1) ? CH_BEL : 8'($urandom_range(255)));
        end
    endtask

    task automatic test_random(input int sidle, input int rstall, input int items);
        int start;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        start = bytes_sent;
        while (bytes_sent - start < items) send_random_sequence();
        // return to ground before the next phase
        send_byte(CH_BEL);
        send_byte(CH_BEL);
        wait_drained();
    endtask

    initial begin
        errors = 0;
        bytes_sent = 0;
        results_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.in_byte = '0;
        mdl_mode = M_GROUND;
        mdl_cnt = 0;
        mdl_done = 1'b0;
        mdl_content = 1'b0;
        mdl_attr = '0;
        foreach (mdl_par[i]) mdl_par[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_controls();
        test_csi_commands();
        test_sgr();
        test_escapes();
        // sender holds off until everything is out
        wait_drained();
        test_random(0, 0, 30);
        test_random(68, 0, 30);
        test_random(0, 68, 30);
        test_random(8, 8, 30);

        $display("covered %0d bytes and %0d results: controls, csi moves, sgr, osc",
                 bytes_sent, results_seen);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== ansi_escape_sequence_parser.f =====
rtl/aesp_pkg.sv
rtl/aesp_if.sv
rtl/aesp_queue.sv
rtl/aesp_front.sv
rtl/aesp_back.sv
rtl/ansi_escape_sequence_parser.sv
rtl/aesp_checker.sv
bench/testbench.sv
